### rtl/core/hrp_pkg.sv
// shared types, constants and keyword tables for the http request header parser
// no dependencies; imported by hrp_step and the top level
`default_nettype none

package hrp_pkg;

    localparam int MAX_REQUEST_BYTES = 1024;
    localparam int CNT_W             = $clog2(MAX_REQUEST_BYTES + 1);

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_C     = 8'h43;

    localparam logic [1:0] ST_PENDING  = 2'd0;
    localparam logic [1:0] ST_COMPLETE = 2'd1;
    localparam logic [1:0] ST_BAD      = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // request line tokens
    localparam logic [1:0] TOK_METHOD  = 2'd0;
    localparam logic [1:0] TOK_URI     = 2'd1;
    localparam logic [1:0] TOK_VERSION = 2'd2;
    localparam logic [1:0] TOK_EXTRA   = 2'd3;

    localparam logic CMD_DATA    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    typedef enum logic [1:0] {PH_LINE, PH_HEAD, PH_DONE} phase_t;
    typedef enum logic [1:0] {KIND_UNDECIDED, KIND_HOST, KIND_CONN, KIND_OTHER} kind_t;
    typedef enum logic [1:0] {STG_NAME, STG_SPACES, STG_VALUE, STG_IDLE} stage_t;
    typedef enum logic [2:0] {W_GET, W_VER, W_HOST, W_CONN, W_CLOSE} word_sel_t;

    typedef struct packed {
        phase_t             phase;
        logic               cr_pending;
        logic [1:0]         token_number;
        logic               inside_token;
        logic [3:0]         match_position;
        logic               still_matching;
        kind_t              header_kind;
        stage_t             value_stage;
        logic               line_empty;
        logic               persist;
        logic [1:0]         final_code;
        logic [CNT_W-1:0]   byte_count;
    } state_t;

    typedef struct packed {
        logic [1:0] status;
        logic       persist;
        logic       uri_valid;
        logic       host_valid;
        logic       host_start;
        logic [7:0] out_byte;
    } result_t;

    localparam state_t STATE_RESET = '{
        phase:          PH_LINE,
        cr_pending:     1'b0,
        token_number:   TOK_METHOD,
        inside_token:   1'b0,
        match_position: 4'd0,
        still_matching: 1'b1,
        header_kind:    KIND_UNDECIDED,
        value_stage:    STG_NAME,
        line_empty:     1'b1,
        persist:        1'b1,
        final_code:     ST_PENDING,
        byte_count:     '0
    };

    // keywords left-aligned in 11 characters
    localparam logic [87:0] STR_GET   = {"GET", 64'h0};
    localparam logic [87:0] STR_VER   = {"HTTP/1.1", 24'h0};
    localparam logic [87:0] STR_HOST  = {"HOST:", 48'h0};
    localparam logic [87:0] STR_CONN  = "CONNECTION:";
    localparam logic [87:0] STR_CLOSE = {"CLOSE", 48'h0};

    function automatic logic [3:0] word_len(word_sel_t w);
        logic [3:0] len;
        unique case (w)
            W_GET:   len = 4'd3;
            W_VER:   len = 4'd8;
            W_HOST:  len = 4'd5;
            W_CONN:  len = 4'd11;
            W_CLOSE: len = 4'd5;
            default: len = 4'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] word_char(word_sel_t w, logic [3:0] idx);
        logic [87:0] str;
        logic [87:0] shifted;
        unique case (w)
            W_GET:   str = STR_GET;
            W_VER:   str = STR_VER;
            W_HOST:  str = STR_HOST;
            W_CONN:  str = STR_CONN;
            W_CLOSE: str = STR_CLOSE;
            default: str = '0;
        endcase
        shifted = str << {idx, 3'b000};
        return shifted[87:80];
    endfunction

    function automatic logic [7:0] upcase(logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7a) ? b - 8'h20 : b;
    endfunction

endpackage

`default_nettype wire

### rtl/core/hrp_step.sv
// next-state and result logic for one request byte
// depends on hrp_pkg
`default_nettype none

module hrp_step (
    input  hrp_pkg::state_t  cur,
    input  logic             cmd,
    input  logic [7:0]       data_byte,
    output hrp_pkg::state_t  nxt,
    output hrp_pkg::result_t res
);
    import hrp_pkg::*;

    logic       uri_o;
    logic       host_o;
    logic       start_o;
    logic [7:0] byte_o;
    logic [7:0] up;
    logic       tok_ok;
    logic [3:0] mp;
    logic       sm;
    logic       skip;
    kind_t      kind;
    word_sel_t  sel;

    assign up = upcase(data_byte);

    always_comb
    begin
        nxt     = cur;
        uri_o   = 1'b0;
        host_o  = 1'b0;
        start_o = 1'b0;
        byte_o  = 8'd0;
        tok_ok  = 1'b1;
        mp      = cur.match_position;
        sm      = cur.still_matching;
        skip    = 1'b0;
        kind    = cur.header_kind;
        sel     = W_GET;

        // a token that ends now must have matched its keyword completely
        if (cur.token_number == TOK_METHOD)
            tok_ok = cur.still_matching && cur.match_position == word_len(W_GET);
        else if (cur.token_number == TOK_VERSION)
            tok_ok = cur.still_matching && cur.match_position == word_len(W_VER);

        if (cmd == CMD_RESTART)
        begin
            nxt = STATE_RESET;
        end
        else if (cur.phase != PH_DONE)
        begin
            nxt.byte_count = cur.byte_count + 1'b1;
            if (cur.cr_pending)
            begin
                nxt.cr_pending = 1'b0;
                if (data_byte != CH_LF)
                begin
                    nxt.phase      = PH_DONE;
                    nxt.final_code = ST_BAD;
                end
                else if (cur.phase == PH_LINE)
                begin
                    if (cur.inside_token)
                    begin
                        nxt.inside_token = 1'b0;
                        if (cur.token_number != TOK_EXTRA)
                            nxt.token_number = cur.token_number + 1'b1;
                    end
                    if ((cur.inside_token && !tok_ok) || nxt.token_number < TOK_VERSION)
                    begin
                        nxt.phase      = PH_DONE;
                        nxt.final_code = ST_BAD;
                    end
                    else
                    begin
                        nxt.phase          = PH_HEAD;
                        nxt.header_kind    = KIND_UNDECIDED;
                        nxt.value_stage    = STG_NAME;
                        nxt.match_position = 4'd0;
                        nxt.line_empty     = 1'b1;
                    end
                end
                else if (cur.line_empty)
                begin
                    nxt.phase      = PH_DONE;
                    nxt.final_code = ST_COMPLETE;
                end
                else
                begin
                    // host line with no value bytes: empty host replaces the old one
                    if (cur.header_kind == KIND_HOST && cur.value_stage == STG_SPACES)
                        start_o = 1'b1;
                    nxt.header_kind    = KIND_UNDECIDED;
                    nxt.value_stage    = STG_NAME;
                    nxt.match_position = 4'd0;
                    nxt.line_empty     = 1'b1;
                end
            end
            else if (data_byte == CH_CR)
            begin
                nxt.cr_pending = 1'b1;
            end
            else if (data_byte == CH_LF)
            begin
                nxt.phase      = PH_DONE;
                nxt.final_code = ST_BAD;
            end
            else if (cur.phase == PH_LINE)
            begin
                if (data_byte == CH_SP)
                begin
                    if (cur.inside_token)
                    begin
                        nxt.inside_token = 1'b0;
                        if (cur.token_number != TOK_EXTRA)
                            nxt.token_number = cur.token_number + 1'b1;
                        if (!tok_ok)
                        begin
                            nxt.phase      = PH_DONE;
                            nxt.final_code = ST_BAD;
                        end
                    end
                end
                else
                begin
                    if (!cur.inside_token)
                    begin
                        if (cur.token_number == TOK_EXTRA ||
                            (cur.token_number == TOK_URI && data_byte != CH_SLASH))
                        begin
                            skip           = 1'b1;
                            nxt.phase      = PH_DONE;
                            nxt.final_code = ST_BAD;
                        end
                        else
                        begin
                            nxt.inside_token = 1'b1;
                            mp = 4'd0;
                            sm = 1'b1;
                        end
                    end
                    if (!skip)
                    begin
                        if (cur.token_number == TOK_URI)
                        begin
                            uri_o  = 1'b1;
                            byte_o = data_byte;
                        end
                        else if (cur.token_number == TOK_METHOD ||
                                 cur.token_number == TOK_VERSION)
                        begin
                            sel = (cur.token_number == TOK_METHOD) ? W_GET : W_VER;
                            if (mp < word_len(sel) && sm && word_char(sel, mp) == up)
                                mp = mp + 1'b1;
                            else
                                sm = 1'b0;
                            if (!sm)
                            begin
                                nxt.phase      = PH_DONE;
                                nxt.final_code = ST_BAD;
                            end
                        end
                        nxt.match_position = mp;
                        nxt.still_matching = sm;
                    end
                end
            end
            else
            begin
                nxt.line_empty = 1'b0;
                unique case (cur.value_stage)
                    STG_NAME:
                    begin
                        if (kind == KIND_UNDECIDED)
                        begin
                            kind = (up == CH_H) ? KIND_HOST
                                 : ((up == CH_C) ? KIND_CONN : KIND_OTHER);
                            mp = 4'd0;
                        end
                        if (kind == KIND_HOST || kind == KIND_CONN)
                        begin
                            sel = (kind == KIND_HOST) ? W_HOST : W_CONN;
                            if (mp < word_len(sel) && word_char(sel, mp) == up)
                            begin
                                mp = mp + 1'b1;
                                if (mp == word_len(sel))
                                    nxt.value_stage = STG_SPACES;
                            end
                            else
                            begin
                                kind = KIND_OTHER;
                            end
                        end
                        nxt.header_kind    = kind;
                        nxt.match_position = mp;
                    end
                    STG_SPACES, STG_VALUE:
                    begin
                        if (cur.value_stage == STG_VALUE || data_byte != CH_SP)
                        begin
                            nxt.value_stage = STG_VALUE;
                            if (cur.header_kind == KIND_HOST)
                            begin
                                host_o  = 1'b1;
                                start_o = (cur.value_stage == STG_SPACES);
                                byte_o  = data_byte;
                            end
                            else
                            begin
                                // prefix match of the connection value against close
                                if (cur.value_stage == STG_SPACES)
                                    mp = 4'd0;
                                if (mp < word_len(W_CLOSE) && word_char(W_CLOSE, mp) == up)
                                begin
                                    mp = mp + 1'b1;
                                    if (mp == word_len(W_CLOSE))
                                    begin
                                        nxt.persist     = 1'b0;
                                        nxt.value_stage = STG_IDLE;
                                    end
                                end
                                else
                                begin
                                    nxt.value_stage = STG_IDLE;
                                end
                                nxt.match_position = mp;
                            end
                        end
                    end
                    STG_IDLE:
                    begin
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (nxt.phase != PH_DONE && nxt.byte_count >= CNT_W'(MAX_REQUEST_BYTES))
            begin
                nxt.phase      = PH_DONE;
                nxt.final_code = ST_OVERFLOW;
            end
            if (nxt.phase == PH_DONE && nxt.final_code != ST_COMPLETE)
            begin
                uri_o   = 1'b0;
                host_o  = 1'b0;
                start_o = 1'b0;
                byte_o  = 8'd0;
            end
        end

        res.status     = (nxt.phase == PH_DONE) ? nxt.final_code : ST_PENDING;
        res.persist    = nxt.persist;
        res.uri_valid  = uri_o;
        res.host_valid = host_o;
        res.host_start = start_o;
        res.out_byte   = byte_o;
    end

endmodule

`default_nettype wire

### rtl/core/http_request_header_parser.sv
// Request header parser for HTTP/1.1: takes one request byte (or a restart) per item and
// returns one result item for each, carrying status, keep-alive and the streamed URI or
// Host value byte. It accepts an item every clock cycle while the output is not stalled;
// each result reaches the output through the input register, where the combinational
// step logic updates the parser state and loads the result register.
// A stalled output holds the result register, then the input register, then s_tready.
// The request fails with overflow after MAX_REQUEST_BYTES data bytes without completion.
// top level; depends on hrp_pkg and hrp_step
`default_nettype none

module http_request_header_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tuser,    // [0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [1:0] status, [2] persist, [10:3] out_byte, zero above
    output logic [2:0]  m_tuser     // [0] uri_valid, [1] host_valid, [2] host_start
);
    import hrp_pkg::*;

    logic       in_valid_reg;
    logic       in_valid_next;
    logic       in_cmd_reg;
    logic [7:0] in_byte_reg;
    state_t     state_reg;
    state_t     state_next;
    result_t    step_res;
    logic       out_valid_reg;
    logic       out_valid_next;
    result_t    out_data_reg;
    logic       advance;
    logic       in_take;

    // the input register moves on whenever the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    assign in_valid_next  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    hrp_step u_step (
        .cur       (state_reg),
        .cmd       (in_cmd_reg),
        .data_byte (in_byte_reg),
        .nxt       (state_next),
        .res       (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_cmd_reg  <= s_tuser;
            in_byte_reg <= s_tdata;
        end
        if (advance)
            out_data_reg <= step_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_data_reg.out_byte, out_data_reg.persist,
                       out_data_reg.status};
    assign m_tuser  = {out_data_reg.host_start, out_data_reg.host_valid,
                       out_data_reg.uri_valid};

endmodule

`default_nettype wire

### rtl/core/hrp_checker.sv
// port-level checks for http_request_header_parser, attached by bind
// depends on the top level's port list only
`default_nettype none

module hrp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // a result waiting at the output keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // a byte is never both uri and host
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("uri and host flagged together");

    // out_byte is zero unless it carries a streamed byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] && !m_tuser[1] |-> m_tdata[10:3] == 8'd0)
        else $error("stray out_byte");

    // streamed bytes only while the request is pending or on its completing byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[0] || m_tuser[1] || m_tuser[2])
        |-> (m_tdata[1:0] == 2'd0 || m_tdata[1:0] == 2'd1))
        else $error("streamed byte on a failed request");

endmodule

bind http_request_header_parser hrp_checker u_hrp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

### verif/testbench.sv
// self-checking testbench for http_request_header_parser: directed requests, overflow runs
// and random well-formed or damaged requests under several idling patterns
// depends on hrp_pkg and the parser rtl
module testbench;
    import hrp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tuser = CMD_DATA;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int mismatches = 0;
    int bytes_parsed = 0;
    int quiet_cycles = 0;

    result_t    results_due[$];
    logic [7:0] req_bytes[$];

    // predicted parser state
    phase_t     ps_phase;
    logic       ps_cr;
    logic [1:0] ps_tok;
    logic       ps_in_tok;
    logic [3:0] ps_pos;
    logic       ps_match;
    kind_t      ps_kind;
    stage_t     ps_stage;
    logic       ps_blank;
    logic       ps_keep;
    logic [1:0] ps_code;
    int         ps_count;
    result_t    ps_out;

    http_request_header_parser DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 clk = ~clk;

    function automatic string kw_text(word_sel_t w);
        string txt;
        case (w)
            W_GET:   txt = "GET";
            W_VER:   txt = "HTTP/1.1";
            W_HOST:  txt = "HOST:";
            W_CONN:  txt = "CONNECTION:";
            default: txt = "CLOSE";
        endcase
        return txt;
    endfunction

    function automatic void start_line();
        ps_kind  = KIND_UNDECIDED;
        ps_stage = STG_NAME;
        ps_pos   = 4'd0;
        ps_blank = 1'b1;
    endfunction

    function automatic void parser_clear();
        ps_phase  = PH_LINE;
        ps_cr     = 1'b0;
        ps_tok    = TOK_METHOD;
        ps_in_tok = 1'b0;
        ps_match  = 1'b1;
        ps_keep   = 1'b1;
        ps_code   = ST_PENDING;
        ps_count  = 0;
        start_line();
    endfunction

    function automatic void end_request(logic [1:0] code);
        ps_phase = PH_DONE;
        ps_code  = code;
    endfunction

    // closes the current request line token, returns 0 if it cannot stand
    function automatic logic token_ok();
        logic ok;
        ok = 1'b1;
        if (ps_tok == TOK_METHOD)
            ok = ps_match && ps_pos == 4'd3;
        else if (ps_tok == TOK_VERSION)
            ok = ps_match && ps_pos == 4'd8;
        ps_in_tok = 1'b0;
        if (ps_tok != TOK_EXTRA)
            ps_tok = ps_tok + 2'd1;
        return ok;
    endfunction

    function automatic void match_word(word_sel_t w, logic [7:0] up);
        string kw;
        kw = kw_text(w);
        if (ps_pos < kw.len() && ps_match && kw[ps_pos] == up)
            ps_pos = ps_pos + 4'd1;
        else
            ps_match = 1'b0;
        if (!ps_match)
            end_request(ST_BAD);
    endfunction

    function automatic void close_match(logic [7:0] up);
        string kw;
        kw = kw_text(W_CLOSE);
        if (ps_pos < kw.len() && kw[ps_pos] == up)
        begin
            ps_pos = ps_pos + 4'd1;
            if (ps_pos == kw.len())
            begin
                ps_keep  = 1'b0;
                ps_stage = STG_IDLE;
            end
        end
        else
            ps_stage = STG_IDLE;
    endfunction

    function automatic void request_line_byte(logic [7:0] b, logic [7:0] up);
        if (b == CH_SP)
        begin
            if (ps_in_tok)
            begin
                if (!token_ok())
                    end_request(ST_BAD);
            end
            return;
        end
        if (!ps_in_tok)
        begin
            if (ps_tok == TOK_EXTRA || (ps_tok == TOK_URI && b != CH_SLASH))
            begin
                end_request(ST_BAD);
                return;
            end
            ps_in_tok = 1'b1;
            ps_pos    = 4'd0;
            ps_match  = 1'b1;
        end
        case (ps_tok)
            TOK_METHOD:  match_word(W_GET, up);
            TOK_VERSION: match_word(W_VER, up);
            TOK_URI:
            begin
                ps_out.uri_valid = 1'b1;
                ps_out.out_byte  = b;
            end
            default: ;
        endcase
    endfunction

    function automatic void header_line_byte(logic [7:0] b, logic [7:0] up);
        string kw;
        ps_blank = 1'b0;
        case (ps_stage)
            STG_NAME:
            begin
                if (ps_kind == KIND_UNDECIDED)
                begin
                    ps_kind = (up == CH_H) ? KIND_HOST : ((up == CH_C) ? KIND_CONN : KIND_OTHER);
                    ps_pos  = 4'd0;
                end
                if (ps_kind == KIND_HOST || ps_kind == KIND_CONN)
                begin
                    kw = kw_text(ps_kind == KIND_HOST ? W_HOST : W_CONN);
                    if (ps_pos < kw.len() && kw[ps_pos] == up)
                    begin
                        ps_pos = ps_pos + 4'd1;
                        if (ps_pos == kw.len())
                            ps_stage = STG_SPACES;
                    end
                    else
                        ps_kind = KIND_OTHER;
                end
            end
            STG_SPACES:
            begin
                if (b != CH_SP)
                begin
                    ps_stage = STG_VALUE;
                    if (ps_kind == KIND_HOST)
                    begin
                        ps_out.host_valid = 1'b1;
                        ps_out.host_start = 1'b1;
                        ps_out.out_byte   = b;
                    end
                    else
                    begin
                        ps_pos = 4'd0;
                        close_match(up);
                    end
                end
            end
            STG_VALUE:
            begin
                if (ps_kind == KIND_HOST)
                begin
                    ps_out.host_valid = 1'b1;
                    ps_out.out_byte   = b;
                end
                else
                    close_match(up);
            end
            default: ;
        endcase
    endfunction

    function automatic void line_terminated();
        logic bad;
        bad = 1'b0;
        if (ps_phase == PH_LINE)
        begin
            if (ps_in_tok)
                bad = !token_ok();
            if (bad || ps_tok < TOK_VERSION)
                end_request(ST_BAD);
            else
            begin
                ps_phase = PH_HEAD;
                start_line();
            end
        end
        else if (ps_blank)
            end_request(ST_COMPLETE);
        else
        begin
            // host line with no value: the host is replaced by an empty one
            if (ps_kind == KIND_HOST && ps_stage == STG_SPACES)
                ps_out.host_start = 1'b1;
            start_line();
        end
    endfunction

    // expected result item for one accepted input item
    function automatic result_t parse_item(logic cmd, logic [7:0] b);
        logic [7:0] up;
        up     = (b >= "a" && b <= "z") ? b - 8'd32 : b;
        ps_out = '0;
        if (cmd == CMD_RESTART)
        begin
            parser_clear();
            bytes_parsed++;
        end
        else if (ps_phase != PH_DONE)
        begin
            bytes_parsed++;
            ps_count++;
            if (ps_cr)
            begin
                ps_cr = 1'b0;
                if (b == CH_LF)
                    line_terminated();
                else
                    end_request(ST_BAD);
            end
            else if (b == CH_CR)
                ps_cr = 1'b1;
            else if (b == CH_LF)
                end_request(ST_BAD);
            else if (ps_phase == PH_LINE)
                request_line_byte(b, up);
            else
                header_line_byte(b, up);
            if (ps_phase != PH_DONE && ps_count >= MAX_REQUEST_BYTES)
                end_request(ST_OVERFLOW);
            if (ps_phase == PH_DONE && ps_code != ST_COMPLETE)
            begin
                ps_out.uri_valid  = 1'b0;
                ps_out.host_valid = 1'b0;
                ps_out.host_start = 1'b0;
                ps_out.out_byte   = 8'h00;
            end
        end
        ps_out.status  = (ps_phase == PH_DONE) ? ps_code : ST_PENDING;
        ps_out.persist = ps_keep;
        return ps_out;
    endfunction

    task automatic send_item(input logic cmd, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        results_due.push_back(parse_item(cmd, b));
    endtask

    task automatic send_request();
        send_item(CMD_RESTART, 8'($urandom_range(255)));
        foreach (req_bytes[i])
            send_item(CMD_DATA, req_bytes[i]);
    endtask

    // ordinary character: never space, cr or lf
    function automatic logic [7:0] rand_char();
        logic [7:0] c;
        case ($urandom_range(3))
            0:       c = 8'($urandom_range(8'h7e, 8'h21));
            1:       c = 8'($urandom_range(8'h7b, 8'h60));  // around the lower-case letters
            2:       c = 8'($urandom_range(8'h5b, 8'h40));
            default: c = 8'($urandom_range(255, 0));
        endcase
        if (c == CH_SP || c == CH_CR || c == CH_LF)
            c = c ^ 8'h80;
        return c;
    endfunction

    function automatic logic [7:0] any_byte();
        logic [7:0] c;
        case ($urandom_range(4))
            0:       c = CH_CR;
            1:       c = CH_LF;
            2:       c = CH_SP;
            default: c = rand_char();
        endcase
        return c;
    endfunction

    function automatic void push_text(string s, logic vary_case);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++)
        begin
            c = s[i];
            if (vary_case && $urandom_range(1) && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")))
                c = c ^ 8'h20;
            req_bytes.push_back(c);
        end
    endfunction

    function automatic void push_spaces(int n);
        repeat (n)
            req_bytes.push_back(CH_SP);
    endfunction

    function automatic void push_crlf();
        req_bytes.push_back(CH_CR);
        req_bytes.push_back(CH_LF);
    endfunction

    function automatic void build_random_request();
        int idx;
        req_bytes.delete();
        if ($urandom_range(7) == 0)
        begin
            repeat ($urandom_range(12, 1))
                req_bytes.push_back(any_byte());
            return;
        end
        if ($urandom_range(15) == 0)
            push_spaces($urandom_range(2, 1));
        case ($urandom_range(15))
            0: ;
            1: push_text("get", 1'b1);
            default:
            begin
                push_text("get", 1'b1);
                push_spaces($urandom_range(3, 1));
                req_bytes.push_back($urandom_range(9) == 0 ? rand_char() : CH_SLASH);
                repeat ($urandom_range(6))
                    req_bytes.push_back(rand_char());
                if ($urandom_range(3) != 0)
                begin
                    push_spaces($urandom_range(2, 1));
                    push_text("http/1.1", 1'b1);
                    if ($urandom_range(7) == 0)
                    begin
                        push_spaces(1);
                        req_bytes.push_back(rand_char());
                    end
                end
            end
        endcase
        if ($urandom_range(3) == 0)
            push_spaces($urandom_range(2, 1));
        push_crlf();
        repeat ($urandom_range(3))
        begin
            case ($urandom_range(5))
                0, 1:
                begin
                    push_text("host:", 1'b1);
                    push_spaces($urandom_range(2));
                    repeat ($urandom_range(5))
                        req_bytes.push_back(rand_char());
                end
                2, 3:
                begin
                    push_text("connection:", 1'b1);
                    push_spaces($urandom_range(2));
                    case ($urandom_range(4))
                        0, 1: push_text("close", 1'b1);
                        2:    push_text("clos", 1'b1);
                        3:    push_text("keep-alive", 1'b1);
                        default: push_text("closed", 1'b1);
                    endcase
                end
                default:
                begin
                    case ($urandom_range(3))
                        0: push_text("hostx:", 1'b1);
                        1: push_text("conn:", 1'b1);
                        2: push_text("cookie:", 1'b1);
                        default: push_text("accept:", 1'b1);
                    endcase
                    push_spaces($urandom_range(1));
                    repeat ($urandom_range(4))
                        req_bytes.push_back(rand_char());
                end
            endcase
            push_crlf();
        end
        push_crlf();
        // damage: a stray byte replaced, dropped or added
        if ($urandom_range(5) == 0)
        begin
            idx = $urandom_range(req_bytes.size() - 1);
            case ($urandom_range(2))
                0: req_bytes[idx] = any_byte();
                1: req_bytes.delete(idx);
                default: req_bytes.insert(idx, any_byte());
            endcase
        end
        // cut short so that the next restart lands mid-request
        if ($urandom_range(11) == 0)
        begin
            idx = $urandom_range(req_bytes.size() - 1);
            while (req_bytes.size() > idx)
                void'(req_bytes.pop_back());
        end
        repeat ($urandom_range(2))
            req_bytes.push_back(rand_char());
    endfunction

    task automatic test_basics();
        // lower-case method, odd uri bytes, empty host value, then a byte after completion
        req_bytes.delete();
        push_text("get /", 1'b0);
        req_bytes.push_back(8'hff);
        req_bytes.push_back(8'h00);
        req_bytes.push_back(8'h09);
        push_crlf();
        push_text("Host:", 1'b0);
        push_crlf();
        push_crlf();
        req_bytes.push_back("Z");
        send_request();
        // empty request line
        req_bytes.delete();
        push_crlf();
        send_request();
        // wrong first method byte
        req_bytes.delete();
        push_text("X", 1'b0);
        send_request();
    endtask

    task automatic test_overflow();
        // a header line padded past the byte limit, then bytes that must be ignored
        req_bytes.delete();
        push_text("GET / HTTP/1.1", 1'b1);
        push_crlf();
        push_text("x: ", 1'b0);
        while (req_bytes.size() < MAX_REQUEST_BYTES)
            req_bytes.push_back(rand_char());
        repeat (3)
            req_bytes.push_back(rand_char());
        send_request();
    endtask

    task automatic test_random_requests(input int idle_pct, input int stall, input int n);
        int target;
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        target        = bytes_parsed + n;
        while (bytes_parsed < target)
        begin
            build_random_request();
            send_request();
        end
    endtask

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin : check_results
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status     = m_tdata[1:0];
            got.persist    = m_tdata[2];
            got.out_byte   = m_tdata[10:3];
            got.uri_valid  = m_tuser[0];
            got.host_valid = m_tuser[1];
            got.host_start = m_tuser[2];
            if (results_due.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result item: status %0d keep %b byte %02h", got.status,
                             got.persist, got.out_byte);
                mismatches++;
            end
            else
            begin
                want = results_due.pop_front();
                if (got !== want || m_tdata[15:11] !== 5'd0)
                begin
                    if (mismatches < 10)
                        $display({"mismatch: want status %0d keep %b uri %b host %b start %b ",
                                  "byte %02h, got status %0d keep %b uri %b host %b start %b ",
                                  "byte %02h pad %02h"},
                                 want.status, want.persist, want.uri_valid, want.host_valid,
                                 want.host_start, want.out_byte, got.status, got.persist,
                                 got.uri_valid, got.host_valid, got.host_start, got.out_byte,
                                 m_tdata[15:11]);
                    mismatches++;
                end
            end
        end
    end

    // ends a hung run: counts cycles in which no item moves on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        parser_clear();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basics();
        test_overflow();
        test_random_requests(0, 0, 150);
        test_random_requests(63, 0, 150);
        test_random_requests(0, 63, 150);
        test_random_requests(11, 11, 150);
        s_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
